// File: hdl/i2cms_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
// Used by i2c_master_bit_sequencer and its port checker; no dependencies.
package i2cms_pkg;

    // Word widths on the streams and the configuration port
    localparam int unsigned IN_W   = 16;
    localparam int unsigned OUT_W  = 16;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned DLY_W  = 18;

    // Input word bit positions
    localparam int unsigned IN_OP_LSB  = 0;
    localparam int unsigned IN_TX_LSB  = 3;
    localparam int unsigned IN_ACK_BIT = 11;
    localparam int unsigned IN_SDA_BIT = 12;

    // Result word bit positions
    localparam int unsigned OUT_SCL_BIT  = 0;
    localparam int unsigned OUT_SDA_BIT  = 1;
    localparam int unsigned OUT_OE_BIT   = 2;
    localparam int unsigned OUT_BUSY_BIT = 3;
    localparam int unsigned OUT_DONE_BIT = 4;
    localparam int unsigned OUT_RX_LSB   = 5;
    localparam int unsigned OUT_FAIL_BIT = 13;

    localparam logic [15:0] TICKS_PER_US_RST = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RST  = 8'd250;
    localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

    typedef enum logic [0:0] {
        REG_TICKS_PER_US = 1'b0,
        REG_ACK_TIMEOUT  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_WRITE    = 3'd3,
        OP_READ     = 3'd4,
        OP_WAIT_ACK = 3'd5
    } op_t;

    typedef enum logic [14:0] {
        PH_IDLE      = 15'h0001,
        PH_START_LOW = 15'h0002,
        PH_START_END = 15'h0004,
        PH_STOP_HIGH = 15'h0008,
        PH_STOP_END  = 15'h0010,
        PH_WR_HIGH   = 15'h0020,
        PH_WR_LOW    = 15'h0040,
        PH_WR_NEXT   = 15'h0080,
        PH_RD_HIGH   = 15'h0100,
        PH_RD_LOW    = 15'h0200,
        PH_ACK_LOW   = 15'h0400,
        PH_ACK_HIGH  = 15'h0800,
        PH_ACK_END   = 15'h1000,
        PH_WA_HIGH   = 15'h2000,
        PH_WA_POLL   = 15'h4000
    } phase_t;

endpackage

// File: hdl/i2c_master_bit_sequencer.sv
// I2C master line sequencer: one input word per bus tick, one result word per tick.
// Depends on i2cms_pkg for word layout, command codes and phase encoding.
//
// Usage:
//   Slave stream (s_*): one word per clock tick of bus timing, carrying an
//   optional command (start, stop, write byte, read byte, wait acknowledge),
//   the byte to send, the ack choice for reads and the sampled SDA level.
//   Master stream (m_*): exactly one result word per accepted input word,
//   carrying SCL, SDA drive level and enable, busy, done, last received byte
//   and the acknowledge-failure flag, all as they stand after that tick.
//   Configuration (cfg_*): write ticks_per_us or ack_timeout while idle;
//   a write takes effect at the clock edge where cfg_we is high.
// Timing:
//   Results are registered: the result of a word accepted in one cycle is on
//   m_* in the next cycle. Throughput is one word per cycle when no stall holds
//   it; the state update and result are a single registered pass (a small adder,
//   a compare and the phase decode) between the input handshake and the result register.
//   Bus delays are n * ticks_per_us input words per phase, n being 1, 2 or 4.
// Reset: lines released high and driven, sequencer idle, registers back to
//   100 ticks per microsecond and a timeout of 250 polls; no result pending.
// Stall: the result register holds while m_tready is low, and s_tready drops
//   only when that register is full and not being emptied this cycle.
module i2c_master_bit_sequencer
(
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: operation[2:0], tx_byte[10:3], ack_after_read[11], sda_in[12], zero[15:13]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [i2cms_pkg::IN_W-1:0]    s_tdata,
    // m_tdata: scl[0], sda_out[1], sda_oe[2], busy_res[3], done_res[4],
    //          rx_byte[12:5], ack_fail[13], zero[15:14]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [i2cms_pkg::OUT_W-1:0]   m_tdata,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [i2cms_pkg::CFG_W-1:0]   cfg_data
);

    // Configuration registers
    logic [15:0] ticks_per_us_reg;
    logic [7:0]  ack_timeout_reg;

    // Sequencer state
    i2cms_pkg::phase_t              phase_reg, phase_next;
    logic [3:0]                     bit_count_reg, bit_count_next;
    logic [7:0]                     shift_reg, shift_next;
    logic [i2cms_pkg::DLY_W-1:0]    delay_reg, delay_next;
    logic [7:0]                     poll_count_reg, poll_count_next;
    logic                           ack_choice_reg, ack_choice_next;
    logic                           fail_reg, fail_next;
    logic [7:0]                     rx_reg, rx_next;
    logic                           scl_reg, scl_next;
    logic                           sda_reg, sda_next;
    logic                           oe_reg, oe_next;
    logic                           done_next;

    // Result register
    logic                           m_tvalid_reg;
    logic [i2cms_pkg::OUT_W-1:0]    m_tdata_reg;

    logic                           accept;
    i2cms_pkg::op_t                 in_op;
    logic [7:0]                     in_tx;
    logic                           in_ack;
    logic                           in_sda;

    logic [15:0]                    tick_eff;
    logic [i2cms_pkg::DLY_W-1:0]    dly_1us, dly_2us, dly_4us;
    logic [3:0]                     bit_inc;
    logic [7:0]                     rd_shift;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_op  = i2cms_pkg::op_t'(s_tdata[i2cms_pkg::IN_OP_LSB +: 3]);
    assign in_tx  = s_tdata[i2cms_pkg::IN_TX_LSB +: 8];
    assign in_ack = s_tdata[i2cms_pkg::IN_ACK_BIT];
    assign in_sda = s_tdata[i2cms_pkg::IN_SDA_BIT];

    // Phase lengths minus one; a zero tick rate counts as one
    assign tick_eff = (ticks_per_us_reg == 16'd0) ? 16'd1 : ticks_per_us_reg;
    assign dly_1us  = {2'b00, tick_eff} - i2cms_pkg::DLY_W'(1);
    assign dly_2us  = {1'b0, tick_eff, 1'b0} - i2cms_pkg::DLY_W'(1);
    assign dly_4us  = {tick_eff, 2'b00} - i2cms_pkg::DLY_W'(1);

    assign bit_inc  = bit_count_reg + 4'd1;
    assign rd_shift = {shift_reg[6:0], in_sda};

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        delay_next      = delay_reg;
        poll_count_next = poll_count_reg;
        ack_choice_next = ack_choice_reg;
        fail_next       = fail_reg;
        rx_next         = rx_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        oe_next         = oe_reg;
        done_next       = 1'b0;

        if (phase_reg == i2cms_pkg::PH_IDLE)
        begin
            case (in_op)
                i2cms_pkg::OP_START:
                begin
                    oe_next    = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    delay_next = dly_4us;
                    phase_next = i2cms_pkg::PH_START_LOW;
                end
                i2cms_pkg::OP_STOP:
                begin
                    oe_next    = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    delay_next = dly_4us;
                    phase_next = i2cms_pkg::PH_STOP_HIGH;
                end
                i2cms_pkg::OP_WRITE:
                begin
                    oe_next        = 1'b1;
                    scl_next       = 1'b0;
                    bit_count_next = 4'd0;
                    sda_next       = in_tx[7];
                    shift_next     = {in_tx[6:0], 1'b0};
                    delay_next     = dly_2us;
                    phase_next     = i2cms_pkg::PH_WR_HIGH;
                end
                i2cms_pkg::OP_READ:
                begin
                    oe_next         = 1'b0;
                    scl_next        = 1'b0;
                    bit_count_next  = 4'd0;
                    shift_next      = 8'd0;
                    ack_choice_next = in_ack;
                    delay_next      = dly_2us;
                    phase_next      = i2cms_pkg::PH_RD_HIGH;
                end
                i2cms_pkg::OP_WAIT_ACK:
                begin
                    oe_next         = 1'b0;
                    sda_next        = 1'b1;
                    fail_next       = 1'b0;
                    poll_count_next = 8'd0;
                    delay_next      = dly_1us;
                    phase_next      = i2cms_pkg::PH_WA_HIGH;
                end
                default:
                begin
                    phase_next = i2cms_pkg::PH_IDLE;
                end
            endcase
        end
        else if (delay_reg != '0)
        begin
            delay_next = delay_reg - i2cms_pkg::DLY_W'(1);
        end
        else
        begin
            case (phase_reg)
                i2cms_pkg::PH_START_LOW:
                begin
                    sda_next   = 1'b0;
                    delay_next = dly_4us;
                    phase_next = i2cms_pkg::PH_START_END;
                end
                i2cms_pkg::PH_START_END:
                begin
                    scl_next   = 1'b0;
                    phase_next = i2cms_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                i2cms_pkg::PH_STOP_HIGH:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    delay_next = dly_4us;
                    phase_next = i2cms_pkg::PH_STOP_END;
                end
                i2cms_pkg::PH_STOP_END:
                begin
                    phase_next = i2cms_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                i2cms_pkg::PH_WR_HIGH:
                begin
                    scl_next   = 1'b1;
                    delay_next = dly_2us;
                    phase_next = i2cms_pkg::PH_WR_LOW;
                end
                i2cms_pkg::PH_WR_LOW:
                begin
                    scl_next   = 1'b0;
                    delay_next = dly_2us;
                    phase_next = i2cms_pkg::PH_WR_NEXT;
                end
                i2cms_pkg::PH_WR_NEXT:
                begin
                    bit_count_next = bit_inc;
                    if (bit_inc >= i2cms_pkg::BITS_PER_BYTE)
                    begin
                        phase_next = i2cms_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        // shift out the next bit, MSB first
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        delay_next = dly_2us;
                        phase_next = i2cms_pkg::PH_WR_HIGH;
                    end
                end
                i2cms_pkg::PH_RD_HIGH:
                begin
                    scl_next       = 1'b1;
                    shift_next     = rd_shift;
                    bit_count_next = bit_inc;
                    delay_next     = dly_1us;
                    if (bit_inc >= i2cms_pkg::BITS_PER_BYTE)
                    begin
                        rx_next    = rd_shift;
                        phase_next = i2cms_pkg::PH_ACK_LOW;
                    end
                    else
                    begin
                        phase_next = i2cms_pkg::PH_RD_LOW;
                    end
                end
                i2cms_pkg::PH_RD_LOW:
                begin
                    scl_next   = 1'b0;
                    delay_next = dly_2us;
                    phase_next = i2cms_pkg::PH_RD_HIGH;
                end
                i2cms_pkg::PH_ACK_LOW:
                begin
                    scl_next   = 1'b0;
                    oe_next    = 1'b1;
                    sda_next   = !ack_choice_reg;
                    delay_next = dly_2us;
                    phase_next = i2cms_pkg::PH_ACK_HIGH;
                end
                i2cms_pkg::PH_ACK_HIGH:
                begin
                    scl_next   = 1'b1;
                    delay_next = dly_2us;
                    phase_next = i2cms_pkg::PH_ACK_END;
                end
                i2cms_pkg::PH_ACK_END:
                begin
                    scl_next   = 1'b0;
                    phase_next = i2cms_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                i2cms_pkg::PH_WA_HIGH:
                begin
                    scl_next   = 1'b1;
                    delay_next = dly_1us;
                    phase_next = i2cms_pkg::PH_WA_POLL;
                end
                i2cms_pkg::PH_WA_POLL:
                begin
                    if (!in_sda)
                    begin
                        scl_next   = 1'b0;
                        phase_next = i2cms_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else if (poll_count_reg >= ack_timeout_reg)
                    begin
                        // timed out: flag it and run a full stop
                        fail_next  = 1'b1;
                        oe_next    = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        delay_next = dly_4us;
                        phase_next = i2cms_pkg::PH_STOP_HIGH;
                    end
                    else
                    begin
                        poll_count_next = poll_count_reg + 8'd1;
                    end
                end
                default:
                begin
                    phase_next = i2cms_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_us_reg <= i2cms_pkg::TICKS_PER_US_RST;
            ack_timeout_reg  <= i2cms_pkg::ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (i2cms_pkg::cfg_reg_t'(cfg_index))
                i2cms_pkg::REG_TICKS_PER_US: ticks_per_us_reg <= cfg_data[15:0];
                i2cms_pkg::REG_ACK_TIMEOUT:  ack_timeout_reg  <= cfg_data[7:0];
                default:                     ticks_per_us_reg <= ticks_per_us_reg;
            endcase
        end
    end

    // Advance the sequencer once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cms_pkg::PH_IDLE;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            delay_reg      <= '0;
            poll_count_reg <= 8'd0;
            ack_choice_reg <= 1'b0;
            fail_reg       <= 1'b0;
            rx_reg         <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            oe_reg         <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            delay_reg      <= delay_next;
            poll_count_reg <= poll_count_next;
            ack_choice_reg <= ack_choice_next;
            fail_reg       <= fail_next;
            rx_reg         <= rx_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            oe_reg         <= oe_next;
        end
    end

    // Result register: fill on accept, drop when taken, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {2'b00, fail_next, rx_next, done_next,
                            (phase_next != i2cms_pkg::PH_IDLE), oe_next, sda_next, scl_next};
        end
    end

endmodule

// File: hdl/i2cms_checker.sv
// Port-level checker for i2c_master_bit_sequencer, with its bind statement.
// Depends on i2cms_pkg for the word widths and result bit positions.
module i2cms_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [i2cms_pkg::IN_W-1:0]    s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [i2cms_pkg::OUT_W-1:0]   m_tdata
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Every accepted word yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // Input side never waits on an empty result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with result register empty");

    // Done only pulses once the sequence has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[i2cms_pkg::OUT_DONE_BIT] && m_tdata[i2cms_pkg::OUT_BUSY_BIT]))
        else $error("done and busy both set");

    // Padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[i2cms_pkg::OUT_W-1:i2cms_pkg::OUT_FAIL_BIT+1] == '0))
        else $error("result padding not zero");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/i2c_master_bit_sequencer_checker.sv
`timescale 1ns / 100ps
// Port checker for the I2C master bit sequencer: predicts bus line levels per input word.
// Depends on i2cms_pkg for word layout, command codes, phase encoding and register indexes.
module i2c_master_bit_sequencer_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [i2cms_pkg::IN_W-1:0]    s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [i2cms_pkg::OUT_W-1:0]   m_tdata,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [i2cms_pkg::CFG_W-1:0]   cfg_data,
    output logic                          seq_idle,
    output int unsigned                   pending,
    output int unsigned                   fail_count
);
    import i2cms_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_oe;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       fail;
    } line_state_t;

    // Configuration copy
    logic [15:0] tpu;
    logic [7:0]  ack_to;

    // Sequencer state
    phase_t      ph;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [17:0] dly;
    logic [7:0]  poll_cnt;
    logic        ack_sel;
    logic        fail_q;
    logic [7:0]  rx_hold;
    logic        scl_q;
    logic        sda_q;
    logic        oe_q;

    line_state_t expected_lines[$];
    int unsigned mismatches;

    initial
    begin
        seq_idle   = 1'b1;
        pending    = 0;
        fail_count = 0;
        mismatches = 0;
    end

    // Load the delay counter for n microseconds and move to the next phase
    task automatic hold_for(input int unsigned n, input phase_t nxt);
        int unsigned t;
        t   = (tpu == 16'd0) ? 1 : tpu;
        dly = DLY_W'(n * t - 1);
        ph  = nxt;
    endtask

    task automatic begin_stop();
        oe_q  = 1'b1;
        scl_q = 1'b0;
        sda_q = 1'b0;
        hold_for(4, PH_STOP_HIGH);
    endtask

    task automatic put_bit();
        sda_q = shreg[7];
        shreg = {shreg[6:0], 1'b0};
        hold_for(2, PH_WR_HIGH);
    endtask

    // One bus tick: update the state and queue the line levels it leaves behind
    task automatic advance_tick(input logic [IN_W-1:0] w);
        logic [2:0]  op;
        logic [7:0]  tx;
        logic        ack_in;
        logic        sda_in;
        logic        done_now;
        line_state_t lines;
        op       = w[IN_OP_LSB +: 3];
        tx       = w[IN_TX_LSB +: 8];
        ack_in   = w[IN_ACK_BIT];
        sda_in   = w[IN_SDA_BIT];
        done_now = 1'b0;
        if (ph == PH_IDLE)
        begin
            case (op)
                OP_START:
                begin
                    oe_q  = 1'b1;
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                    hold_for(4, PH_START_LOW);
                end
                OP_STOP:
                    begin_stop();
                OP_WRITE:
                begin
                    oe_q    = 1'b1;
                    scl_q   = 1'b0;
                    bit_cnt = '0;
                    shreg   = tx;
                    put_bit();
                end
                OP_READ:
                begin
                    oe_q    = 1'b0;
                    scl_q   = 1'b0;
                    bit_cnt = '0;
                    shreg   = '0;
                    ack_sel = ack_in;
                    hold_for(2, PH_RD_HIGH);
                end
                OP_WAIT_ACK:
                begin
                    oe_q     = 1'b0;
                    sda_q    = 1'b1;
                    fail_q   = 1'b0;
                    poll_cnt = '0;
                    hold_for(1, PH_WA_HIGH);
                end
                default: ;
            endcase
        end
        else if (dly != '0)
        begin
            dly = dly - 1'b1;
        end
        else
        begin
            case (ph)
                PH_START_LOW:
                begin
                    sda_q = 1'b0;
                    hold_for(4, PH_START_END);
                end
                PH_START_END:
                begin
                    scl_q    = 1'b0;
                    ph       = PH_IDLE;
                    done_now = 1'b1;
                end
                PH_STOP_HIGH:
                begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    hold_for(4, PH_STOP_END);
                end
                PH_STOP_END:
                begin
                    ph       = PH_IDLE;
                    done_now = 1'b1;
                end
                PH_WR_HIGH:
                begin
                    scl_q = 1'b1;
                    hold_for(2, PH_WR_LOW);
                end
                PH_WR_LOW:
                begin
                    scl_q = 1'b0;
                    hold_for(2, PH_WR_NEXT);
                end
                PH_WR_NEXT:
                begin
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= BITS_PER_BYTE)
                    begin
                        ph       = PH_IDLE;
                        done_now = 1'b1;
                    end
                    else
                        put_bit();
                end
                PH_RD_HIGH:
                begin
                    // sample SDA on the same tick that SCL rises
                    scl_q   = 1'b1;
                    shreg   = {shreg[6:0], sda_in};
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= BITS_PER_BYTE)
                    begin
                        rx_hold = shreg;
                        hold_for(1, PH_ACK_LOW);
                    end
                    else
                        hold_for(1, PH_RD_LOW);
                end
                PH_RD_LOW:
                begin
                    scl_q = 1'b0;
                    hold_for(2, PH_RD_HIGH);
                end
                PH_ACK_LOW:
                begin
                    scl_q = 1'b0;
                    oe_q  = 1'b1;
                    sda_q = !ack_sel;
                    hold_for(2, PH_ACK_HIGH);
                end
                PH_ACK_HIGH:
                begin
                    scl_q = 1'b1;
                    hold_for(2, PH_ACK_END);
                end
                PH_ACK_END:
                begin
                    scl_q    = 1'b0;
                    ph       = PH_IDLE;
                    done_now = 1'b1;
                end
                PH_WA_HIGH:
                begin
                    scl_q = 1'b1;
                    hold_for(1, PH_WA_POLL);
                end
                PH_WA_POLL:
                begin
                    if (!sda_in)
                    begin
                        scl_q    = 1'b0;
                        ph       = PH_IDLE;
                        done_now = 1'b1;
                    end
                    else if (poll_cnt >= ack_to)
                    begin
                        fail_q = 1'b1;
                        begin_stop();
                    end
                    else
                        poll_cnt = poll_cnt + 1'b1;
                end
                default:
                    ph = PH_IDLE;
            endcase
        end
        lines.scl     = scl_q;
        lines.sda_out = sda_q;
        lines.sda_oe  = oe_q;
        lines.busy    = (ph != PH_IDLE);
        lines.done    = done_now;
        lines.rx      = rx_hold;
        lines.fail    = fail_q;
        expected_lines.push_back(lines);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        line_state_t want;
        line_state_t got;
        if (!rst_n)
        begin
            tpu      = TICKS_PER_US_RST;
            ack_to   = ACK_TIMEOUT_RST;
            ph       = PH_IDLE;
            bit_cnt  = '0;
            shreg    = '0;
            dly      = '0;
            poll_cnt = '0;
            ack_sel  = 1'b0;
            fail_q   = 1'b0;
            rx_hold  = '0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            oe_q     = 1'b1;
            expected_lines.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TICKS_PER_US: tpu    = cfg_data;
                    REG_ACK_TIMEOUT:  ack_to = cfg_data[7:0];
                    default: ;
                endcase
            end
            // Retire the result first: it always belongs to an earlier word
            if (m_tvalid && m_tready)
            begin
                got.scl     = m_tdata[OUT_SCL_BIT];
                got.sda_out = m_tdata[OUT_SDA_BIT];
                got.sda_oe  = m_tdata[OUT_OE_BIT];
                got.busy    = m_tdata[OUT_BUSY_BIT];
                got.done    = m_tdata[OUT_DONE_BIT];
                got.rx      = m_tdata[OUT_RX_LSB +: 8];
                got.fail    = m_tdata[OUT_FAIL_BIT];
                if (expected_lines.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] result word with nothing expected: %h", $realtime, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display({"[%0t] result mismatch (expected/actual): scl %b/%b ",
                                      "sda_out %b/%b sda_oe %b/%b busy %b/%b done %b/%b ",
                                      "rx_byte %h/%h ack_fail %b/%b"},
                                     $realtime, want.scl, got.scl, want.sda_out, got.sda_out,
                                     want.sda_oe, got.sda_oe, want.busy, got.busy,
                                     want.done, got.done, want.rx, got.rx,
                                     want.fail, got.fail);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                advance_tick(s_tdata);
        end
        seq_idle   <= (ph == PH_IDLE);
        pending    <= expected_lines.size();
        fail_count <= mismatches;
    end

endmodule

// File: dv/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the I2C master bit sequencer: clock, reset, tick stimulus and verdict.
// Depends on i2cms_pkg, i2c_master_bit_sequencer and i2c_master_bit_sequencer_checker.
module i2c_master_bit_sequencer_tb;
    import i2cms_pkg::*;

    // Cycles without any accepted word or taken result before the run is abandoned
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    // Input words to send; no new command starts once this many have gone
    localparam int unsigned ITEMS_TARGET = 520;
    // Input words after which both sides stop idling
    localparam int unsigned QUIET_FROM = 440;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // s_tdata: operation[2:0], tx_byte[10:3], ack_after_read[11], sda_in[12], zero[15:13]
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // m_tdata: scl[0], sda_out[1], sda_oe[2], busy_res[3], done_res[4],
    //          rx_byte[12:5], ack_fail[13], zero[15:14]
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we = 1'b0;
    logic [0:0]        cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    logic              seq_idle;
    int unsigned       pending;
    int unsigned       fail_count;

    // Drop all idling on both sides when set
    logic              quiet = 1'b0;
    int unsigned       ready_hold = 0;
    int unsigned       stall_cycles = 0;
    int unsigned       words_sent = 0;

    i2c_master_bit_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2c_master_bit_sequencer_checker line_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .seq_idle   (seq_idle),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Result side back-pressure: hold m_tready low in bursts of random length
    always @(posedge clk)
    begin
        if (quiet || !rst_n)
            m_tready <= 1'b1;
        else if (ready_hold != 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 5);
        end
        else
            m_tready <= 1'b1;
    end

    // Abandon the run if neither stream moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [IN_W-1:0] pack_word(input logic [2:0] op, input logic [7:0] tx,
                                                   input logic ack, input logic sda);
        logic [IN_W-1:0] w;
        w = '0;
        w[IN_OP_LSB +: 3] = op;
        w[IN_TX_LSB +: 8] = tx;
        w[IN_ACK_BIT]     = ack;
        w[IN_SDA_BIT]     = sda;
        return w;
    endfunction

    // SDA is high on pct percent of ticks
    function automatic logic sda_bit(input int unsigned pct);
        return ($urandom_range(0, 99) < pct);
    endfunction

    // Chance that the slave holds SDA high while an acknowledge is polled
    function automatic int unsigned ack_bias();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 60;
            2:       return 90;
            default: return 100;
        endcase
    endfunction

    // Present one word, maybe after a gap, and hold it until accepted
    task automatic push_word(input logic [IN_W-1:0] w);
        if (!quiet && $urandom_range(0, 11) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (words_sent >= QUIET_FROM)
            quiet <= 1'b1;
    endtask

    // Issue one command, then stream ticks until the sequencer is known to be idle.
    // The checker's idle flag lags by one word, so stop only once it reads idle after
    // a word that cannot have started anything. Stray commands while busy are noise.
    // Once the word budget is spent no further command is started.
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input int unsigned sda_pct);
        logic [2:0] fop;
        logic       harmless;
        if (words_sent >= ITEMS_TARGET)
            return;
        push_word(pack_word(op, tx, ack, sda_bit(sda_pct)));
        harmless = (op == OP_NONE) || (op > OP_WAIT_ACK);
        while (!(seq_idle && harmless))
        begin
            if (!seq_idle && $urandom_range(0, 49) == 0)
                fop = 3'($urandom_range(OP_START, OP_WAIT_ACK));
            else if ($urandom_range(0, 29) == 0)
                fop = 3'($urandom_range(6, 7));
            else
                fop = OP_NONE;
            push_word(pack_word(fop, 8'($urandom), 1'($urandom), sda_bit(sda_pct)));
            harmless = (fop == OP_NONE) || (fop > OP_WAIT_ACK);
        end
    endtask

    // A well-formed transfer: start, address, acknowledge, data, stop
    task automatic bus_transaction();
        int unsigned n;
        int unsigned k;
        run_cmd(OP_START, 8'($urandom), 1'($urandom), 50);
        run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 50);
        run_cmd(OP_WAIT_ACK, 8'($urandom), 1'($urandom), ack_bias());
        n = $urandom_range(1, 2);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 50);
                run_cmd(OP_WAIT_ACK, 8'($urandom), 1'($urandom), ack_bias());
            end
            else
                run_cmd(OP_READ, 8'($urandom), 1'($urandom), 50);
        end
        run_cmd(OP_STOP, 8'($urandom), 1'($urandom), 50);
    endtask

    // Wait until every result is back, then let the block run on idle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input logic [15:0] tpu, input logic [7:0] timeout);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_TICKS_PER_US;
        cfg_data  <= tpu;
        @(posedge clk);
        cfg_index <= REG_ACK_TIMEOUT;
        cfg_data  <= {8'h00, timeout};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned round;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: line levels straight out of reset
        run_cmd(OP_NONE, 8'h00, 1'b0, 50);

        // Directed: fastest timing, timeout register at one
        set_config(16'd1, 8'd1);
        run_cmd(OP_START, 8'hFF, 1'b1, 50);
        run_cmd(OP_WRITE, 8'h00, 1'b0, 50);
        run_cmd(OP_WAIT_ACK, 8'hFF, 1'b1, 100);
        run_cmd(OP_WRITE, 8'hFF, 1'b1, 50);
        run_cmd(OP_READ, 8'h00, 1'b1, 0);
        run_cmd(OP_READ, 8'hFF, 1'b0, 100);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 0);
        run_cmd(3'd6, 8'hFF, 1'b1, 50);
        run_cmd(3'd7, 8'h00, 1'b0, 50);
        run_cmd(OP_STOP, 8'h00, 1'b0, 50);

        // Directed: zero ticks per microsecond acts as one, zero timeout fails at once
        set_config(16'd0, 8'd0);
        run_cmd(OP_WAIT_ACK, 8'h5A, 1'b0, 100);
        run_cmd(OP_READ, 8'h00, 1'b1, 50);
        run_cmd(OP_START, 8'h00, 1'b0, 50);

        // Directed: longest timeout, acknowledged straight away
        set_config(16'd1, 8'd255);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 0);

        // Random: mostly well-formed transfers, the rest single commands of any code
        round = 0;
        while (words_sent < ITEMS_TARGET)
        begin
            // no configuration change once idling has stopped
            if (round % 3 == 0 && !quiet)
            begin
                case ((round / 3) % 4)
                    0:       set_config(16'($urandom_range(1, 2)), 8'($urandom_range(0, 6)));
                    1:       set_config(16'd2, 8'($urandom_range(0, 3)));
                    2:       set_config(16'd1, 8'($urandom_range(1, 6)));
                    default: set_config(16'($urandom_range(0, 2)), 8'($urandom_range(0, 4)));
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 50);
            else
                bus_transaction();
            round++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
